/* rtl/soft_clip_saturator_dc_block_defines.svh */
// assertion macros used by the soft clip saturator controller
`ifndef SOFT_CLIP_SATURATOR_DC_BLOCK_DEFINES_SVH
`define SOFT_CLIP_SATURATOR_DC_BLOCK_DEFINES_SVH
// same-cycle implication, clocked on clk and disabled in reset
`define SCSDB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk and disabled in reset
`define SCSDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/scsdb_pkg.sv */
// types and constants of the soft clip saturator with dc blocker
package scsdb_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int DRIVE_W = 16;
  localparam int STEP_W  = 32;
  localparam int COEF_W  = 24;
  localparam int NORM_W  = 17;
  localparam int CHAN_W  = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRIVE_LEVEL    = 3'd0,
    REG_DRIFT_STEP     = 3'd1,
    REG_DC_COEFFICIENT = 3'd2,
    REG_SHAPER_NORM    = 3'd3,
    REG_CHANNEL_COUNT  = 3'd4
  } reg_index_t;

  // register reset values
  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 16'd0;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd17896;
  localparam logic [COEF_W-1:0]  COEF_RESET  = 24'd16766237;
  localparam logic [NORM_W-1:0]  NORM_RESET  = 17'd86051;
  localparam logic [CHAN_W-1:0]  CHAN_RESET  = 2'd2;
  localparam logic [CHAN_W-1:0]  CHAN_MONO   = 2'd1;

  // drive below this passes frames through
  localparam logic [DRIVE_W-1:0] DRIVE_FLOOR = 16'd66;
  // shaper gain in q2.17 is GAIN_BASE + 5 * drive
  localparam int GAIN_W = 19;
  localparam logic [GAIN_W-1:0] GAIN_BASE = 19'd131072;
  // drift gain width covers sample widths up to 32
  localparam int DRIFT_GAIN_W = 20;
  localparam int DRIFT_W      = 23;

  // rom entry formats
  localparam int SINE_W = 17;
  localparam int TANH_W = 31;
  localparam logic [63:0] Q30        = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE, ST_PHASE, ST_SINE, ST_DRIFT_MUL, ST_DRIFT_RND,
    ST_SUM, ST_GAIN_MUL, ST_LOCATE, ST_TANH_RD, ST_INTERP_MUL,
    ST_INTERP_ADD, ST_NORM_MUL, ST_NORM_RND, ST_DC_DIFF, ST_DC_MUL,
    ST_DC_UPD, ST_OUT_RND, ST_OUT_SAT, ST_RESULT
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PHASE, OP_SINE, OP_DRIFT_MUL, OP_DRIFT_RND,
    OP_SUM, OP_GAIN_MUL, OP_LOCATE, OP_TANH_RD, OP_INTERP_MUL,
    OP_INTERP_ADD, OP_NORM_MUL, OP_NORM_RND, OP_DC_DIFF, OP_DC_MUL,
    OP_DC_UPD, OP_OUT_RND, OP_OUT_SAT, OP_RESULT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic stereo;
    logic out_free;
  } status_t;

endpackage

/* rtl/scsdb_in_if.sv */
// input frame channel
interface scsdb_in_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;
  logic                           block_end;

  modport source (output valid, output left_in, output right_in, output block_end,
                  input ready);
  modport sink (input valid, input left_in, input right_in, input block_end,
                output ready);
endinterface

/* rtl/scsdb_out_if.sv */
// output frame channel
interface scsdb_out_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic                           block_end_out;

  modport source (output valid, output left_out, output right_out, output block_end_out,
                  input ready);
  modport sink (input valid, input left_out, input right_out, input block_end_out,
                output ready);
endinterface

/* rtl/soft_clip_saturator_dc_block.sv */
// frames go straight from load to the result state when drive is below the floor; otherwise
// the 13-step shared channel unit is walked once per active channel after a 4-step drift stage
// a new frame is accepted only in idle, after the previous result has entered the output
// register, and the result waits while that register still holds a frame not yet taken
// reset: synchronous, active high; registers to defaults, phase and dc trackers to zero
module soft_clip_saturator_dc_block import scsdb_pkg::*; #(
  parameter int TANH_TABLE_DEPTH = 1024,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 24,
  parameter int MAX_CHANNELS     = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  scsdb_in_if.sink               sample_in,
  scsdb_out_if.source            sample_out
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  scsdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (sample_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  scsdb_datapath #(
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .MAX_CHANNELS     (MAX_CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .left_in       (sample_in.left_in),
    .right_in      (sample_in.right_in),
    .block_end     (sample_in.block_end),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (sample_out.valid),
    .out_ready     (sample_out.ready),
    .left_out      (sample_out.left_out),
    .right_out     (sample_out.right_out),
    .block_end_out (sample_out.block_end_out)
  );

endmodule

/* rtl/scsdb_datapath.sv */
// datapath: config registers, state, roms, shared channel arithmetic, output register
module scsdb_datapath import scsdb_pkg::*; #(
  parameter int TANH_TABLE_DEPTH = 1024,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 24,
  parameter int MAX_CHANNELS     = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in,
  input  logic                           block_end,
  input  cmd_t                           cmd,
  output status_t                        status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  output logic                           block_end_out
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int F      = SAMPLE_WIDTH - 1;
  localparam int SAW    = $clog2(SINE_TABLE_DEPTH);
  localparam int TAW    = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int VW     = W + 8;
  localparam int MAG_W  = W + GAIN_W;
  localparam int POS_W  = MAG_W + TAW;
  localparam int IDX_W  = POS_W - (F + 19);
  localparam int PH_W   = STEP_W + SAW + 1;
  localparam logic [63:0] DRIFT_GAIN = ((64'd1 << F) + 64'd2500) / 64'd5000;
  localparam logic [39:0] OUT_RND = (F <= 30) ? (40'd1 << (30 - F)) : 40'd0;
  localparam int SHR = 31 - F;
  localparam logic [39:0] POS_LIM = (40'd1 << F) - 40'd1;
  localparam logic [39:0] NEG_LIM = 40'd1 << F;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_TABLE_DEPTH+1];

  // long division by shift and subtract, used to build the tables
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sine rom in q1.15 over one turn
  function automatic sine_rom_t build_sine();
    sine_rom_t   r;
    logic [63:0] p, quad, rr, x, x2, t, s;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      p    = udiv64(64'(k) << 32, 64'(SINE_TABLE_DEPTH));
      quad = p >> 30;
      rr   = p & 64'h3FFF_FFFF;
      if (quad[0]) rr = Q30 - rr;
      x  = (rr * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30;
      for (int i = 0; i < 5; i++) begin
        t = Q30 - udiv64((x2 * t) >> 30, SINE_DIV[i]);
      end
      s = (((x * t) >> 30) + 64'd16384) >> 15;
      r[k] = (quad >= 64'd2) ? SINE_W'(-s) : SINE_W'(s);
    end
    return r;
  endfunction

  // tanh rom in q1.30 over 0 to 4
  function automatic tanh_rom_t build_tanh();
    tanh_rom_t   r;
    logic [63:0] z, term, sum, e;
    for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
      z    = udiv64(64'(k) << 30, 64'(2 * TANH_TABLE_DEPTH));
      term = Q30;
      sum  = Q30;
      for (int n = 1; n <= 12; n++) begin
        term = udiv64((term * z) >> 30, 64'(n));
        sum  = sum + term;
      end
      e = udiv64(Q30 * Q30, sum);
      for (int i = 0; i < 4; i++) begin
        e = (e * e) >> 30;
      end
      r[k] = TANH_W'(udiv64((Q30 - e) << 30, Q30 + e));
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam tanh_rom_t TANH_ROM = build_tanh();

  // configuration registers
  logic [DRIVE_W-1:0] drive_level;
  logic [STEP_W-1:0]  drift_step;
  logic [COEF_W-1:0]  dc_coefficient;
  logic [NORM_W-1:0]  shaper_norm;
  logic [CHAN_W-1:0]  channel_count;

  // item state
  logic [STEP_W-1:0]  drift_phase;
  logic signed [31:0] dc_track [MAX_CHANNELS];

  // working registers
  logic signed [W-1:0]       left_q, right_q;
  logic                      block_end_q;
  logic signed [W-1:0]       res_left, res_right;
  logic [GAIN_W-1:0]         gain;
  logic [COEF_W:0]           dk;
  logic [35:0]               drift_p1;
  logic signed [SINE_W-1:0]  sine_q;
  logic [51:0]               drift_prod;
  logic                      drift_neg;
  logic signed [DRIFT_W-1:0] drift;
  logic [W-1:0]              vabs;
  logic                      vneg;
  logic [MAG_W-1:0]          mag;
  logic [TAW-1:0]            addr0, addr1;
  logic [15:0]               frac;
  logic [TANH_W-1:0]         e0, e1;
  logic [46:0]               interp;
  logic [31:0]               yv;
  logic [48:0]               yn;
  logic signed [33:0]        ws;
  logic [34:0]               dd_abs;
  logic                      dd_neg;
  logic [59:0]               dc_prod;
  logic signed [37:0]        dc_new;
  logic [39:0]               orr;
  logic                      oneg;

  // combinational helpers
  logic [PH_W-1:0]         ph_scaled;
  logic [SAW-1:0]          sine_idx;
  logic [15:0]             sine_abs;
  logic [21:0]             drift_mag;
  logic signed [W-1:0]     x_sel;
  logic signed [VW-1:0]    v_sum;
  logic [POS_W-1:0]        pos;
  logic [IDX_W-1:0]        idx_full;
  logic                    tanh_sat;
  logic [32:0]             ys;
  logic signed [31:0]      dc_cur;
  logic signed [34:0]      dd;
  logic [35:0]             dc_step;
  logic signed [37:0]      dcn;
  logic signed [38:0]      ov;
  logic [38:0]             om;
  logic [39:0]             clamped;
  logic signed [W-1:0]     res_val;

  always_comb begin
    ph_scaled = PH_W'(drift_phase) * PH_W'(SINE_TABLE_DEPTH);
    sine_idx  = ph_scaled[STEP_W +: SAW];
    sine_abs  = sine_q[SINE_W-1] ? 16'(-sine_q) : 16'(sine_q);
    drift_mag = 22'((drift_prod + (52'd1 << 30)) >> 31);
    x_sel     = cmd.ch ? right_q : left_q;
    v_sum     = VW'(x_sel) + VW'(drift);
    pos       = POS_W'(mag) * POS_W'(TANH_TABLE_DEPTH);
    idx_full  = pos[POS_W-1 -: IDX_W];
    tanh_sat  = idx_full >= IDX_W'(TANH_TABLE_DEPTH);
    ys        = 33'((yn + 49'h8000) >> 16);
    dc_cur    = (MAX_CHANNELS > 1 && cmd.ch) ? dc_track[MAX_CHANNELS-1] : dc_track[0];
    dd        = 35'(ws) - 35'(dc_cur);
    dc_step   = 36'((dc_prod + (60'd1 << 23)) >> 24);
    dcn       = dd_neg ? 38'(dc_cur) - 38'(dc_step) : 38'(dc_cur) + 38'(dc_step);
    ov        = 39'(ws) - 39'(dc_new);
    om        = ov[38] ? 39'(-ov) : 39'(ov);
    if (oneg) begin
      clamped = (orr > NEG_LIM) ? NEG_LIM : orr;
      res_val = W'(-clamped);
    end else begin
      clamped = (orr > POS_LIM) ? POS_LIM : orr;
      res_val = W'(clamped);
    end
  end

  assign status.bypass   = drive_level < DRIVE_FLOOR;
  assign status.stereo   = (channel_count != CHAN_MONO) && (MAX_CHANNELS >= 2);
  assign status.out_free = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_level    <= DRIVE_RESET;
      drift_step     <= STEP_RESET;
      dc_coefficient <= COEF_RESET;
      shaper_norm    <= NORM_RESET;
      channel_count  <= CHAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE_LEVEL:    drive_level    <= cfg_data[DRIVE_W-1:0];
        REG_DRIFT_STEP:     drift_step     <= cfg_data[STEP_W-1:0];
        REG_DC_COEFFICIENT: dc_coefficient <= cfg_data[COEF_W-1:0];
        REG_SHAPER_NORM:    shaper_norm    <= cfg_data[NORM_W-1:0];
        REG_CHANNEL_COUNT:  channel_count  <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator and dc trackers
  always_ff @(posedge clk) begin
    if (rst) begin
      drift_phase <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) dc_track[i] <= '0;
    end else begin
      if (cmd.op == OP_PHASE) drift_phase <= drift_phase + drift_step;
      if (cmd.op == OP_DC_UPD) begin
        if (MAX_CHANNELS > 1 && cmd.ch) dc_track[MAX_CHANNELS-1] <= dcn[31:0];
        else dc_track[0] <= dcn[31:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_RESULT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // shared arithmetic steps
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        left_q      <= left_in;
        right_q     <= right_in;
        block_end_q <= block_end;
        res_left    <= left_in;
        res_right   <= right_in;
        gain        <= GAIN_BASE + GAIN_W'({drive_level, 2'b00}) + GAIN_W'(drive_level);
        dk          <= (COEF_W+1)'(1 << COEF_W) - (COEF_W+1)'(dc_coefficient);
        drift_p1    <= 36'(drive_level) * 36'(DRIFT_GAIN[DRIFT_GAIN_W-1:0]);
      end
      OP_SINE:      sine_q <= SINE_ROM[sine_idx];
      OP_DRIFT_MUL: begin
        drift_prod <= 52'(drift_p1) * 52'(sine_abs);
        drift_neg  <= sine_q[SINE_W-1];
      end
      OP_DRIFT_RND: drift <= drift_neg ? -DRIFT_W'(drift_mag) : DRIFT_W'(drift_mag);
      OP_SUM: begin
        vneg <= v_sum[VW-1];
        vabs <= v_sum[VW-1] ? W'(-v_sum) : W'(v_sum);
      end
      OP_GAIN_MUL:  mag <= MAG_W'(vabs) * MAG_W'(gain);
      OP_LOCATE: begin
        frac <= pos[F+3 +: 16];
        if (tanh_sat) begin
          addr0 <= TAW'(TANH_TABLE_DEPTH);
          addr1 <= TAW'(TANH_TABLE_DEPTH);
        end else begin
          addr0 <= idx_full[TAW-1:0];
          addr1 <= idx_full[TAW-1:0] + 1'b1;
        end
      end
      OP_TANH_RD: begin
        e0 <= TANH_ROM[addr0];
        e1 <= TANH_ROM[addr1];
      end
      OP_INTERP_MUL: interp <= 47'(e1 - e0) * 47'(frac);
      OP_INTERP_ADD: yv <= 32'(e0) + 32'((48'(interp) + 48'h8000) >> 16);
      OP_NORM_MUL:   yn <= 49'(yv) * 49'(shaper_norm);
      OP_NORM_RND:   ws <= vneg ? -34'(ys) : 34'(ys);
      OP_DC_DIFF: begin
        dd_neg <= dd[34];
        dd_abs <= dd[34] ? 35'(-dd) : 35'(dd);
      end
      OP_DC_MUL:  dc_prod <= 60'(dd_abs) * 60'(dk);
      OP_DC_UPD:  dc_new <= dcn;
      OP_OUT_RND: begin
        oneg <= ov[38];
        orr  <= ({1'b0, om} + OUT_RND + {1'b0, om}) >> SHR;
      end
      OP_OUT_SAT: begin
        if (cmd.ch) res_right <= res_val;
        else res_left <= res_val;
      end
      OP_RESULT: begin
        left_out      <= res_left;
        right_out     <= res_right;
        block_end_out <= block_end_q;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/scsdb_ctrl.sv */
// controller: sequences the shared datapath once per active channel unless drive is below the floor
`include "soft_clip_saturator_dc_block_defines.svh"
module scsdb_ctrl import scsdb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   ch, ch_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ch_next    = ch;
    cmd.op     = OP_NONE;
    cmd.ch     = ch;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ch_next  = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = status.bypass ? ST_RESULT : ST_PHASE;
        end
      end
      ST_PHASE:      begin cmd.op = OP_PHASE;      state_next = ST_SINE;       end
      ST_SINE:       begin cmd.op = OP_SINE;       state_next = ST_DRIFT_MUL;  end
      ST_DRIFT_MUL:  begin cmd.op = OP_DRIFT_MUL;  state_next = ST_DRIFT_RND;  end
      ST_DRIFT_RND:  begin cmd.op = OP_DRIFT_RND;  state_next = ST_SUM;        end
      ST_SUM:        begin cmd.op = OP_SUM;        state_next = ST_GAIN_MUL;   end
      ST_GAIN_MUL:   begin cmd.op = OP_GAIN_MUL;   state_next = ST_LOCATE;     end
      ST_LOCATE:     begin cmd.op = OP_LOCATE;     state_next = ST_TANH_RD;    end
      ST_TANH_RD:    begin cmd.op = OP_TANH_RD;    state_next = ST_INTERP_MUL; end
      ST_INTERP_MUL: begin cmd.op = OP_INTERP_MUL; state_next = ST_INTERP_ADD; end
      ST_INTERP_ADD: begin cmd.op = OP_INTERP_ADD; state_next = ST_NORM_MUL;   end
      ST_NORM_MUL:   begin cmd.op = OP_NORM_MUL;   state_next = ST_NORM_RND;   end
      ST_NORM_RND:   begin cmd.op = OP_NORM_RND;   state_next = ST_DC_DIFF;    end
      ST_DC_DIFF:    begin cmd.op = OP_DC_DIFF;    state_next = ST_DC_MUL;     end
      ST_DC_MUL:     begin cmd.op = OP_DC_MUL;     state_next = ST_DC_UPD;     end
      ST_DC_UPD:     begin cmd.op = OP_DC_UPD;     state_next = ST_OUT_RND;    end
      ST_OUT_RND:    begin cmd.op = OP_OUT_RND;    state_next = ST_OUT_SAT;    end
      ST_OUT_SAT: begin
        cmd.op = OP_OUT_SAT;
        // right channel follows the left one in stereo
        if (!ch && status.stereo) begin
          ch_next    = 1'b1;
          state_next = ST_SUM;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // checks
  `SCSDB_ASSERT_SAME(a_result_free, cmd.op == OP_RESULT, status.out_free, "result over full output")
  `SCSDB_ASSERT_NEXT(a_bypass_direct, state == ST_IDLE && in_valid && status.bypass, state == ST_RESULT, "bypass did not skip")
  `SCSDB_ASSERT_SAME(a_right_stereo, state != ST_IDLE && ch, status.stereo, "right pass in mono")
  `SCSDB_ASSERT_NEXT(a_second_channel, state == ST_OUT_SAT && !ch && status.stereo, state == ST_SUM && ch, "right channel skipped")

endmodule
